/* rtl/sac_pkg.sv */
`default_nettype none

package sac_pkg;

   // fixed field widths of the streams
   localparam int ADDR_W      = 16;
   localparam int OP_W        = 2;
   localparam int BYTE_W      = 8;
   localparam int DATA_W      = 64;
   localparam int REQ_TDATA_W = 24;
   localparam int REQ_TUSER_W = 2;
   localparam int RSP_TDATA_W = 80;
   localparam int RSP_TUSER_W = 2;

   // access opcodes (any other code behaves as a touch)
   localparam logic [OP_W-1:0] OP_READ  = 2'd0;
   localparam logic [OP_W-1:0] OP_WRITE = 2'd1;

   // controller to datapath commands
   typedef struct packed {
      logic load_req;
      logic mem_clear;
      logic set_read;
      logic capture_lookup;
      logic wb_write;
      logic fill_read;
      logic set_write;
      logic load_rsp;
   } cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic clear_done;
      logic look_hit;
      logic look_dirty;
      logic is_read;
      logic rsp_busy;
   } sts_type;

endpackage

`default_nettype wire

/* rtl/sac_cdiv.sv */
`default_nettype none

// division by a constant: reciprocal multiply, then one correction step
module sac_cdiv #(
   parameter int IN_W    = 16,
   parameter int DIVISOR = 8,
   parameter int QUOT_W  = 13,
   parameter int REM_W   = 3
) (
   input  wire logic              clock,
   input  wire logic [IN_W-1:0]   dividend,
   output logic      [QUOT_W-1:0] quotient,
   output logic      [REM_W-1:0]  remainder
);

   localparam int PROD_W = 2 * IN_W;
   localparam int QD_W   = IN_W + 17;
   localparam logic [IN_W-1:0] RECIP = IN_W'((1 << IN_W) / DIVISOR);
   localparam logic [QD_W-1:0] DIV_Q = QD_W'(DIVISOR);

   logic [IN_W-1:0]   dvd_ff;
   logic [PROD_W-1:0] prod_ff;
   logic [PROD_W-1:0] prod_in;
   logic [IN_W-1:0]   q_est;
   logic [QD_W-1:0]   q_times_d;
   logic [QD_W-1:0]   rem_est;
   logic              fix;
   logic [IN_W-1:0]   q_fix;
   logic [QD_W-1:0]   r_fix;
   logic [QUOT_W-1:0] quot_ff;
   logic [REM_W-1:0]  rem_ff;

   // first stage: estimate, never more than one below the true quotient
   assign prod_in = PROD_W'(dividend) * PROD_W'(RECIP);

   always_ff @(posedge clock) begin
      dvd_ff  <= dividend;
      prod_ff <= prod_in;
   end

   // second stage: remainder of the estimate and correction
   assign q_est     = prod_ff[PROD_W-1:IN_W];
   assign q_times_d = QD_W'(q_est) * DIV_Q;
   assign rem_est   = QD_W'(dvd_ff) - q_times_d;
   assign fix       = (rem_est >= DIV_Q);
   assign q_fix     = fix ? q_est + IN_W'(1) : q_est;
   assign r_fix     = fix ? rem_est - DIV_Q : rem_est;

   always_ff @(posedge clock) begin
      quot_ff <= QUOT_W'(q_fix);
      rem_ff  <= REM_W'(r_fix);
   end

   assign quotient  = quot_ff;
   assign remainder = rem_ff;

endmodule

`default_nettype wire

/* rtl/sac_ctrl.sv */
`default_nettype none

module sac_ctrl
   import sac_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_tvalid,
   output logic      req_tready,
   input  var  sts_type sts,
   output cmd_type   cmd
);

   localparam logic [3:0] ST_CLEAR     = 4'd0;
   localparam logic [3:0] ST_IDLE      = 4'd1;
   localparam logic [3:0] ST_DECODE    = 4'd2;
   localparam logic [3:0] ST_LOOKUP    = 4'd3;
   localparam logic [3:0] ST_COMPARE   = 4'd4;
   localparam logic [3:0] ST_WB_CALC   = 4'd5;
   localparam logic [3:0] ST_WB_WRITE  = 4'd6;
   localparam logic [3:0] ST_FILL_READ = 4'd7;
   localparam logic [3:0] ST_UPDATE    = 4'd8;

   // cycles spent in the address split and in the write-back address path
   localparam logic [1:0] DECODE_WAIT = 2'd3;
   localparam logic [1:0] WB_WAIT     = 2'd2;

   logic [3:0] state_ff;
   logic [3:0] state_in;
   logic [1:0] wait_ff;
   logic [1:0] wait_in;
   logic       go;

   // update may finish unless a read result still blocks the output register
   assign go = (state_ff == ST_UPDATE) & ~(sts.is_read & sts.rsp_busy);

   // next state
   always_comb begin
      state_in = state_ff;
      wait_in  = wait_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (sts.clear_done) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ST_DECODE;
               wait_in  = DECODE_WAIT;
            end
         end
         ST_DECODE: begin
            if (wait_ff == '0) state_in = ST_LOOKUP;
            else wait_in = wait_ff - 2'd1;
         end
         ST_LOOKUP: begin
            state_in = ST_COMPARE;
         end
         ST_COMPARE: begin
            priority if (sts.look_hit) begin
               state_in = ST_UPDATE;
            end else if (sts.look_dirty) begin
               state_in = ST_WB_CALC;
               wait_in  = WB_WAIT;
            end else begin
               state_in = ST_FILL_READ;
            end
         end
         ST_WB_CALC: begin
            if (wait_ff == '0) state_in = ST_WB_WRITE;
            else wait_in = wait_ff - 2'd1;
         end
         ST_WB_WRITE: begin
            state_in = ST_FILL_READ;
         end
         ST_FILL_READ: begin
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            if (go) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         wait_ff  <= '0;
      end else begin
         state_ff <= state_in;
         wait_ff  <= wait_in;
      end
   end

   // commands
   assign req_tready         = (state_ff == ST_IDLE);
   assign cmd.load_req       = (state_ff == ST_IDLE) & req_tvalid;
   assign cmd.mem_clear      = (state_ff == ST_CLEAR);
   assign cmd.set_read       = (state_ff == ST_LOOKUP);
   assign cmd.capture_lookup = (state_ff == ST_COMPARE);
   assign cmd.wb_write       = (state_ff == ST_WB_WRITE);
   assign cmd.fill_read      = (state_ff == ST_FILL_READ);
   assign cmd.set_write      = go;
   assign cmd.load_rsp       = go & sts.is_read;

endmodule

`default_nettype wire

/* rtl/sac_datapath.sv */
`default_nettype none

module sac_datapath
   import sac_pkg::*;
#(
   parameter int NUM_SETS   = 16,
   parameter int NUM_WAYS   = 4,
   parameter int LINE_BYTES = 8,
   parameter int MEM_LINES  = 8192
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  var  cmd_type                cmd,
   output sts_type                     sts,
   input  wire logic [REQ_TDATA_W-1:0] req_tdata,
   input  wire logic [REQ_TUSER_W-1:0] req_tuser,
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic      [RSP_TDATA_W-1:0] rsp_tdata,
   output logic      [RSP_TUSER_W-1:0] rsp_tuser
);

   localparam int OFF_W     = $clog2(LINE_BYTES);
   localparam int LINE_BITS = 8 * LINE_BYTES;
   localparam int LA_MAX    = ((1 << ADDR_W) - 1) / LINE_BYTES;
   localparam int LA_W      = $clog2(LA_MAX + 1);
   localparam int SET_W     = $clog2(NUM_SETS);
   localparam int TAG_W     = $clog2(LA_MAX / NUM_SETS + 1);
   localparam int WAY_W     = $clog2(NUM_WAYS);
   localparam int MEM_W     = $clog2(MEM_LINES);
   localparam logic [WAY_W-1:0] NEWEST   = WAY_W'(NUM_WAYS - 1);
   localparam logic [MEM_W-1:0] CLR_LAST = MEM_W'(MEM_LINES - 1);

   // request registers
   logic [ADDR_W-1:0] addr_ff;
   logic [OP_W-1:0]   op_ff;
   logic [BYTE_W-1:0] wbyte_ff;

   // address split
   logic [LA_W-1:0]  line_addr;
   logic [OFF_W-1:0] off_idx;
   logic [TAG_W-1:0] tag_idx;
   logic [SET_W-1:0] set_idx;
   logic [MEM_W-1:0] fill_idx;
   logic [MEM_W-1:0] wb_idx;
   logic [LA_W-1:0]  wb_line_ff;
   logic [LA_W-1:0]  wb_line_in;

   // set memories, one row per set
   logic [NUM_WAYS-1:0][TAG_W-1:0]     tag_mem   [NUM_SETS];
   logic [NUM_WAYS-1:0]                dirty_mem [NUM_SETS];
   logic [NUM_WAYS-1:0][WAY_W-1:0]     rank_mem  [NUM_SETS];
   logic [NUM_WAYS-1:0][LINE_BITS-1:0] line_mem  [NUM_SETS];
   logic [NUM_SETS-1:0]                set_vld_ff;

   logic [NUM_WAYS-1:0][TAG_W-1:0]     tag_rd_ff;
   logic [NUM_WAYS-1:0]                dirty_rd_ff;
   logic [NUM_WAYS-1:0][WAY_W-1:0]     rank_rd_ff;
   logic [NUM_WAYS-1:0][LINE_BITS-1:0] line_rd_ff;
   logic                               row_vld_ff;

   logic [NUM_WAYS-1:0][TAG_W-1:0]     cur_tag;
   logic [NUM_WAYS-1:0]                cur_dirty;
   logic [NUM_WAYS-1:0][WAY_W-1:0]     cur_rank;
   logic [NUM_WAYS-1:0][LINE_BITS-1:0] cur_line;

   logic [NUM_WAYS-1:0][TAG_W-1:0]     new_tag;
   logic [NUM_WAYS-1:0]                new_dirty;
   logic [NUM_WAYS-1:0][WAY_W-1:0]     new_rank;
   logic [NUM_WAYS-1:0][LINE_BITS-1:0] new_line;
   logic [LINE_BITS-1:0]               sel_line;

   // lookup
   logic             look_hit;
   logic [WAY_W-1:0] hit_way;
   logic [WAY_W-1:0] old_way;
   logic [WAY_W-1:0] look_way;
   logic             hit_ff;
   logic [WAY_W-1:0] way_ff;
   logic             prior_ff;

   // backing memory
   logic [LINE_BITS-1:0] back_mem [MEM_LINES];
   logic [MEM_W-1:0]     clr_cnt_ff;
   logic [MEM_W-1:0]     bm_addr;
   logic                 bm_we;
   logic [LINE_BITS-1:0] bm_wdata;
   logic [LINE_BITS-1:0] fill_data_ff;

   // output register
   logic                rsp_valid_ff;
   logic [ADDR_W-1:0]   rsp_addr_ff;
   logic [DATA_W-1:0]   rsp_line_ff;
   logic                rsp_hit_ff;
   logic                rsp_dirty_ff;

   // capture request on transfer
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         addr_ff  <= req_tdata[ADDR_W-1:0];
         wbyte_ff <= req_tdata[ADDR_W +: BYTE_W];
         op_ff    <= req_tuser;
      end
   end

   // byte offset and line address, then set, tag and memory line
   sac_cdiv #(
      .IN_W(ADDR_W), .DIVISOR(LINE_BYTES), .QUOT_W(LA_W), .REM_W(OFF_W)
   ) u_div_line (
      .clock(clock), .dividend(addr_ff), .quotient(line_addr), .remainder(off_idx)
   );

   sac_cdiv #(
      .IN_W(LA_W), .DIVISOR(NUM_SETS), .QUOT_W(TAG_W), .REM_W(SET_W)
   ) u_div_set (
      .clock(clock), .dividend(line_addr), .quotient(tag_idx), .remainder(set_idx)
   );

   sac_cdiv #(
      .IN_W(LA_W), .DIVISOR(MEM_LINES), .QUOT_W(LA_W), .REM_W(MEM_W)
   ) u_div_fill (
      .clock(clock), .dividend(line_addr), .quotient(), .remainder(fill_idx)
   );

   // set memory read and write
   always_ff @(posedge clock) begin
      if (cmd.set_write) begin
         tag_mem[set_idx]   <= new_tag;
         dirty_mem[set_idx] <= new_dirty;
         rank_mem[set_idx]  <= new_rank;
         line_mem[set_idx]  <= new_line;
      end
      if (cmd.set_read) begin
         tag_rd_ff   <= tag_mem[set_idx];
         dirty_rd_ff <= dirty_mem[set_idx];
         rank_rd_ff  <= rank_mem[set_idx];
         line_rd_ff  <= line_mem[set_idx];
      end
   end

   // a set never written reads as its reset contents
   always_ff @(posedge clock) begin
      if (reset) begin
         set_vld_ff <= '0;
         row_vld_ff <= 1'b0;
      end else begin
         if (cmd.set_write) set_vld_ff[set_idx] <= 1'b1;
         if (cmd.set_read) row_vld_ff <= set_vld_ff[set_idx];
      end
   end

   always_comb begin
      for (int w = 0; w < NUM_WAYS; w++) begin
         cur_tag[w]   = row_vld_ff ? tag_rd_ff[w] : '0;
         cur_dirty[w] = row_vld_ff & dirty_rd_ff[w];
         cur_rank[w]  = row_vld_ff ? rank_rd_ff[w] : WAY_W'(w);
         cur_line[w]  = row_vld_ff ? line_rd_ff[w] : '0;
      end
   end

   // tag compare and oldest way, lowest way wins
   always_comb begin
      look_hit = 1'b0;
      hit_way  = '0;
      old_way  = '0;
      for (int w = NUM_WAYS - 1; w >= 0; w--) begin
         if (cur_tag[w] == tag_idx) begin
            look_hit = 1'b1;
            hit_way  = WAY_W'(w);
         end
         if (cur_rank[w] == '0) old_way = WAY_W'(w);
      end
      look_way = look_hit ? hit_way : old_way;
   end

   always_ff @(posedge clock) begin
      if (cmd.capture_lookup) begin
         hit_ff   <= look_hit;
         way_ff   <= look_way;
         prior_ff <= cur_dirty[look_way];
      end
   end

   // victim line address for write-back
   assign wb_line_in = LA_W'(cur_tag[way_ff]) * LA_W'(NUM_SETS) + LA_W'(set_idx);

   always_ff @(posedge clock) begin
      wb_line_ff <= wb_line_in;
   end

   sac_cdiv #(
      .IN_W(LA_W), .DIVISOR(MEM_LINES), .QUOT_W(LA_W), .REM_W(MEM_W)
   ) u_div_wb (
      .clock(clock), .dividend(wb_line_ff), .quotient(), .remainder(wb_idx)
   );

   // backing memory port: clearing sweep, write-back or fill
   always_comb begin
      bm_we    = cmd.mem_clear | cmd.wb_write;
      bm_wdata = cmd.mem_clear ? '0 : cur_line[way_ff];
      priority if (cmd.mem_clear) bm_addr = clr_cnt_ff;
      else if (cmd.wb_write) bm_addr = wb_idx;
      else bm_addr = fill_idx;
   end

   always_ff @(posedge clock) begin
      if (bm_we) back_mem[bm_addr] <= bm_wdata;
      if (cmd.fill_read) fill_data_ff <= back_mem[bm_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) clr_cnt_ff <= '0;
      else if (cmd.mem_clear) clr_cnt_ff <= clr_cnt_ff + MEM_W'(1);
   end

   // new set row: fill, byte write, dirty and recency
   always_comb begin
      new_tag   = cur_tag;
      new_dirty = cur_dirty;
      new_line  = cur_line;
      sel_line  = hit_ff ? cur_line[way_ff] : fill_data_ff;
      if (op_ff == OP_WRITE) sel_line[{off_idx, 3'b000} +: BYTE_W] = wbyte_ff;
      new_line[way_ff]  = sel_line;
      new_tag[way_ff]   = hit_ff ? cur_tag[way_ff] : tag_idx;
      new_dirty[way_ff] = (op_ff == OP_WRITE) | (hit_ff & cur_dirty[way_ff]);
      for (int w = 0; w < NUM_WAYS; w++) begin
         new_rank[w] = (cur_rank[w] > cur_rank[way_ff]) ? cur_rank[w] - WAY_W'(1)
                                                        : cur_rank[w];
      end
      new_rank[way_ff] = NEWEST;
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         priority if (cmd.load_rsp) rsp_valid_ff <= 1'b1;
         else if (rsp_tready) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_addr_ff  <= addr_ff;
         rsp_line_ff  <= DATA_W'(sel_line);
         rsp_hit_ff   <= hit_ff;
         rsp_dirty_ff <= prior_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_line_ff, rsp_addr_ff};
   assign rsp_tuser  = {rsp_dirty_ff, rsp_hit_ff};

   // status
   assign sts.clear_done = (clr_cnt_ff == CLR_LAST);
   assign sts.look_hit   = look_hit;
   assign sts.look_dirty = cur_dirty[look_way];
   assign sts.is_read    = (op_ff == OP_READ);
   assign sts.rsp_busy   = rsp_valid_ff & ~rsp_tready;

endmodule

`default_nettype wire

/* rtl/set_assoc_writeback_cache.sv */
// Set-associative write-back cache with LRU replacement over a backing memory.
// Request stream (req_*): one access per transfer, address and write byte in
// tdata, opcode in tuser (read, write byte, anything else touches the line).
// Response stream (rsp_*): one transfer per read, carrying the echoed address,
// the whole line, the hit flag and the dirty bit held before the access.
// Writes and touches return nothing.
// One access is worked on at a time. A hit finishes soonest, a clean miss adds
// the fill read and a miss with a dirty victim adds the write-back, before the
// next request is taken; a read result is loaded as its access ends. The access
// time is set by the two-stage constant dividers that split the address, the
// registered set read and the single port of the backing memory shared by
// write-back and fill.
// After reset the backing memory is swept to zero, one line a cycle, over all
// MEM_LINES lines (8192 by default); req_tready stays low until it ends.
// Cache sets read as tag zero, clean and zero data until first written.
// The result sits in an output register; a new request is taken while it
// waits, and a later read holds in its last step until rsp_tready frees it.
`default_nettype none

module set_assoc_writeback_cache
   import sac_pkg::*;
#(
   parameter int NUM_SETS   = 16,
   parameter int NUM_WAYS   = 4,
   parameter int LINE_BYTES = 8,
   parameter int MEM_LINES  = 8192
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   // [15:0] address, [23:16] write_byte
   input  wire logic [REQ_TDATA_W-1:0] req_tdata,
   // [1:0] opcode
   input  wire logic [REQ_TUSER_W-1:0] req_tuser,
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   // [15:0] read_address, [79:16] line_data
   output logic      [RSP_TDATA_W-1:0] rsp_tdata,
   // [0] hit, [1] prior_dirty
   output logic      [RSP_TUSER_W-1:0] rsp_tuser
);

   cmd_type cmd;
   sts_type sts;

   sac_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   sac_datapath #(
      .NUM_SETS   (NUM_SETS),
      .NUM_WAYS   (NUM_WAYS),
      .LINE_BYTES (LINE_BYTES),
      .MEM_LINES  (MEM_LINES)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

`default_nettype wire

/* rtl/sac_checker.sv */
`default_nettype none

module sac_checker
   import sac_pkg::*;
(
   input wire logic                   clock,
   input wire logic                   reset,
   input wire logic                   req_tvalid,
   input wire logic                   req_tready,
   input wire logic                   rsp_tvalid,
   input wire logic                   rsp_tready,
   input wire logic [RSP_TDATA_W-1:0] rsp_tdata,
   input wire logic [RSP_TUSER_W-1:0] rsp_tuser
);

   // reset empties the output and starts the memory sweep
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && !req_tready)
      else $error("output valid or request ready right after reset");

   // a stalled result holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed or vanished");

   // one access at a time: the address split keeps the request side closed
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready ##1 !req_tready)
      else $error("request taken while an access is in flight");

   // a result is loaded only at the end of an access
   a_rsp_after_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(!req_tready))
      else $error("result appeared while the block was idle");

endmodule

bind set_assoc_writeback_cache sac_checker u_checker (.*);

`default_nettype wire

/* tb/sv/set_assoc_writeback_cache_checker.sv */
`timescale 1ns / 1ps

// watches both streams, keeps an image of the cache and backing memory and
// compares every read result against the oldest one due
module set_assoc_writeback_cache_checker
   import sac_pkg::*;
#(
   parameter int NUM_SETS   = 16,
   parameter int NUM_WAYS   = 4,
   parameter int LINE_BYTES = 8,
   parameter int MEM_LINES  = 8192
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   input  wire logic                   req_tready,
   // [15:0] address, [23:16] write_byte
   input  wire logic [REQ_TDATA_W-1:0] req_tdata,
   // [1:0] opcode
   input  wire logic [REQ_TUSER_W-1:0] req_tuser,
   input  wire logic                   rsp_tvalid,
   input  wire logic                   rsp_tready,
   // [15:0] read_address, [79:16] line_data
   input  wire logic [RSP_TDATA_W-1:0] rsp_tdata,
   // [0] hit, [1] prior_dirty
   input  wire logic [RSP_TUSER_W-1:0] rsp_tuser,
   output int                          mismatch_count,
   output int                          reads_outstanding,
   output int                          reads_checked,
   output int                          hit_count,
   output int                          miss_count,
   output int                          writeback_count
);

   localparam logic [DATA_W-1:0] LINE_MASK =
      (LINE_BYTES >= 8) ? '1 : ((64'd1 << (8 * LINE_BYTES)) - 64'd1);

   typedef struct packed {
      logic [ADDR_W-1:0] address;
      logic [DATA_W-1:0] line;
      logic              hit;
      logic              prior_dirty;
   } read_result_type;

   // image of the cache arrays and the memory behind them
   logic [ADDR_W-1:0] tag_of        [NUM_SETS][NUM_WAYS];
   logic              dirty_of      [NUM_SETS][NUM_WAYS];
   logic [DATA_W-1:0] line_of       [NUM_SETS][NUM_WAYS];
   int unsigned       age_of        [NUM_SETS][NUM_WAYS];
   logic [DATA_W-1:0] backing_lines [MEM_LINES];

   read_result_type reads_due [$];

   task automatic clear_cache_image();
      for (int s = 0; s < NUM_SETS; s++) begin
         for (int w = 0; w < NUM_WAYS; w++) begin
            tag_of[s][w]   = '0;
            dirty_of[s][w] = 1'b0;
            line_of[s][w]  = '0;
            age_of[s][w]   = w;
         end
      end
      for (int m = 0; m < MEM_LINES; m++) begin
         backing_lines[m] = '0;
      end
      reads_due.delete();
      mismatch_count  = 0;
      reads_checked   = 0;
      hit_count       = 0;
      miss_count      = 0;
      writeback_count = 0;
   endtask

   task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                  input logic [DATA_W-1:0] want);
      $display("%0t ns: read result %0d, %s: got %h, wanted %h",
               $time, reads_checked, what, got, want);
      mismatch_count++;
   endtask

   // one access against the cache image; reads leave a result due
   task automatic apply_access(input logic [ADDR_W-1:0] addr, input logic [OP_W-1:0] op,
                               input logic [BYTE_W-1:0] wbyte);
      int unsigned       offset, line_no, set_no, way, old_rank, home;
      logic [ADDR_W-1:0] tag_val;
      logic              found, prior;
      read_result_type   due;
      offset  = addr % LINE_BYTES;
      line_no = addr / LINE_BYTES;
      set_no  = line_no % NUM_SETS;
      tag_val = ADDR_W'(line_no / NUM_SETS);
      found   = 1'b0;
      way     = 0;
      // lowest way holding the tag wins; reset tags of zero count as matches
      for (int w = NUM_WAYS - 1; w >= 0; w--) begin
         if (tag_of[set_no][w] == tag_val) begin
            found = 1'b1;
            way   = w;
         end
      end
      if (!found) begin
         // victim is the oldest way of the set
         for (int w = NUM_WAYS - 1; w >= 0; w--) begin
            if (age_of[set_no][w] == 0) way = w;
         end
         prior = dirty_of[set_no][way];
         if (prior) begin
            home = (tag_of[set_no][way] * NUM_SETS + set_no) % MEM_LINES;
            backing_lines[home] = line_of[set_no][way] & LINE_MASK;
            writeback_count++;
         end
         dirty_of[set_no][way] = 1'b0;
         tag_of[set_no][way]   = tag_val;
         line_of[set_no][way]  = backing_lines[line_no % MEM_LINES] & LINE_MASK;
         miss_count++;
      end else begin
         prior = dirty_of[set_no][way];
         hit_count++;
      end
      // accessed way becomes the newest
      old_rank = age_of[set_no][way];
      for (int w = 0; w < NUM_WAYS; w++) begin
         if (age_of[set_no][w] > old_rank) age_of[set_no][w]--;
      end
      age_of[set_no][way] = NUM_WAYS - 1;
      if (op == OP_WRITE) begin
         line_of[set_no][way][8 * offset +: BYTE_W] = wbyte;
         line_of[set_no][way] = line_of[set_no][way] & LINE_MASK;
         dirty_of[set_no][way] = 1'b1;
      end else if (op == OP_READ) begin
         due.address     = addr;
         due.line        = line_of[set_no][way] & LINE_MASK;
         due.hit         = found;
         due.prior_dirty = prior;
         reads_due = {reads_due, due};
      end
   endtask

   task automatic check_read_result();
      read_result_type want;
      if (reads_due.size() == 0) begin
         report_mismatch("transfer with no read due", rsp_tdata[ADDR_W-1:0], '0);
      end else begin
         want = reads_due.pop_front();
         if (rsp_tdata[ADDR_W-1:0] !== want.address)
            report_mismatch("read_address", rsp_tdata[ADDR_W-1:0], want.address);
         if (rsp_tdata[ADDR_W +: DATA_W] !== want.line)
            report_mismatch("line_data", rsp_tdata[ADDR_W +: DATA_W], want.line);
         if (rsp_tuser[0] !== want.hit)
            report_mismatch("hit", rsp_tuser[0], want.hit);
         if (rsp_tuser[1] !== want.prior_dirty)
            report_mismatch("prior_dirty", rsp_tuser[1], want.prior_dirty);
         reads_checked++;
      end
   endtask

   // both channels sampled at the clock edge
   always @(posedge clock) begin
      if (reset) begin
         clear_cache_image();
      end else begin
         if (req_tvalid && req_tready)
            apply_access(req_tdata[ADDR_W-1:0], req_tuser[OP_W-1:0],
                         req_tdata[ADDR_W +: BYTE_W]);
         if (rsp_tvalid && rsp_tready)
            check_read_result();
      end
      reads_outstanding = reads_due.size();
   end

endmodule

/* tb/sv/set_assoc_writeback_cache_tb.sv */
`timescale 1ns / 1ps

module set_assoc_writeback_cache_tb;
   import sac_pkg::*;

   localparam int NUM_SETS   = 16;
   localparam int NUM_WAYS   = 4;
   localparam int LINE_BYTES = 8;
   localparam int MEM_LINES  = 8192;
   localparam int MAX_TAG    = (1 << ADDR_W) / (LINE_BYTES * NUM_SETS) - 1;

   // codes that the block treats as a touch
   localparam logic [OP_W-1:0] OP_TOUCH = 2'd2;
   localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   logic [REQ_TUSER_W-1:0] req_tuser  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic [RSP_TUSER_W-1:0] rsp_tuser;

   // set for a stretch with no idling on either side
   logic steady = 1'b0;
   int   sent_count = 0;

   int mismatches, reads_pending, reads_checked, hits, misses, writebacks;

   set_assoc_writeback_cache #(
      .NUM_SETS   (NUM_SETS),
      .NUM_WAYS   (NUM_WAYS),
      .LINE_BYTES (LINE_BYTES),
      .MEM_LINES  (MEM_LINES)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   set_assoc_writeback_cache_checker #(
      .NUM_SETS   (NUM_SETS),
      .NUM_WAYS   (NUM_WAYS),
      .LINE_BYTES (LINE_BYTES),
      .MEM_LINES  (MEM_LINES)
   ) cache_mirror (
      .clock             (clock),
      .reset             (reset),
      .req_tvalid        (req_tvalid),
      .req_tready        (req_tready),
      .req_tdata         (req_tdata),
      .req_tuser         (req_tuser),
      .rsp_tvalid        (rsp_tvalid),
      .rsp_tready        (rsp_tready),
      .rsp_tdata         (rsp_tdata),
      .rsp_tuser         (rsp_tuser),
      .mismatch_count    (mismatches),
      .reads_outstanding (reads_pending),
      .reads_checked     (reads_checked),
      .hit_count         (hits),
      .miss_count        (misses),
      .writeback_count   (writebacks)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // run limit, far beyond the memory sweep plus the slowest access stream
   initial begin
      #1_000_000;
      $display("Mismatches found");
      $finish;
   end

   // result side stalls at random outside the steady stretch
   always @(posedge clock) begin
      rsp_tready <= steady || ($urandom_range(0, 99) >= 13);
   end

   // one access transfer, with random idle cycles ahead of it outside the steady stretch
   task automatic send_access(input logic [ADDR_W-1:0] addr, input logic [OP_W-1:0] op,
                              input logic [BYTE_W-1:0] wbyte);
      while (!steady && $urandom_range(0, 99) < 13) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {wbyte, addr};
      req_tuser  <= op;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sent_count++;
   endtask

   initial begin
      int unsigned       hot_tags [6];
      int unsigned       hot_sets [2];
      int unsigned       tag_pick, set_pick, roll;
      logic [OP_W-1:0]   op;
      logic [ADDR_W-1:0] addr;
      int                waited;

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // fresh set: tag zero hits way 0, byte lanes at both ends
      send_access(16'h0000, OP_READ, 8'hA5);
      send_access(16'h0007, OP_WRITE, 8'hFF);
      send_access(16'h0000, OP_WRITE, 8'h01);
      send_access(16'h0003, OP_READ, 8'h00);
      // top address, highest tag and set
      send_access(16'hFFFF, OP_WRITE, 8'h80);
      send_access(16'hFFF8, OP_READ, 8'h7F);
      // fill set 0 with new tags until the dirty tag-zero line is evicted
      send_access(16'h0080, OP_TOUCH, 8'h33);
      send_access(16'h0100, OP_SPARE, 8'hCC);
      send_access(16'h0180, OP_READ, 8'h00);
      send_access(16'h0200, OP_READ, 8'h00);
      // tag zero again: refilled from the written-back line
      send_access(16'h0005, OP_READ, 8'h00);
      // duplicate reset tags in set 1: the lowest remaining way hits
      send_access(16'h0288, OP_READ, 8'h00);
      send_access(16'h000F, OP_READ, 8'h00);
      send_access(16'h000C, OP_WRITE, 8'h5A);
      send_access(16'h0008, OP_TOUCH, 8'hFF);
      send_access(16'h0008, OP_READ, 8'hFF);
      // alternating bit patterns in address and byte
      send_access(16'hAAAA, OP_WRITE, 8'h55);
      send_access(16'hAAAA, OP_READ, 8'h00);
      send_access(16'h5555, OP_WRITE, 8'hAA);
      send_access(16'h5550, OP_READ, 8'h00);
      send_access(16'h5555, OP_SPARE, 8'h00);

      // random part: a small pool of tags over a few sets drives evictions
      // and write-backs, with fully random addresses mixed in
      for (int phase = 0; phase < 4; phase++) begin
         steady <= (phase == 2);
         hot_tags[0] = 0;
         hot_tags[1] = MAX_TAG;
         for (int k = 2; k < 6; k++) hot_tags[k] = $urandom_range(0, MAX_TAG);
         hot_sets[0] = $urandom_range(0, NUM_SETS - 1);
         hot_sets[1] = $urandom_range(0, NUM_SETS - 1);
         for (int n = 0; n < 250; n++) begin
            roll = $urandom_range(0, 99);
            if (roll < 40) op = OP_READ;
            else if (roll < 75) op = OP_WRITE;
            else if (roll < 90) op = OP_TOUCH;
            else op = OP_SPARE;
            if ($urandom_range(0, 99) < 80) begin
               tag_pick = hot_tags[$urandom_range(0, 5)];
               if ($urandom_range(0, 99) < 70) set_pick = hot_sets[$urandom_range(0, 1)];
               else set_pick = $urandom_range(0, NUM_SETS - 1);
               addr = ADDR_W'((tag_pick * NUM_SETS + set_pick) * LINE_BYTES
                              + $urandom_range(0, LINE_BYTES - 1));
            end else begin
               addr = ADDR_W'($urandom_range(0, (1 << ADDR_W) - 1));
            end
            send_access(addr, op, BYTE_W'($urandom_range(0, 255)));
         end
      end
      req_tvalid <= 1'b0;
      steady     <= 1'b0;

      // drain outstanding reads, then let the last access settle
      waited = 0;
      while (reads_pending != 0 && waited < 4000) begin
         @(posedge clock);
         waited++;
      end
      repeat (30) @(posedge clock);

      $display("run covered %0d accesses and %0d checked read results",
               sent_count, reads_checked);
      $display("lookups: %0d hits, %0d misses, %0d dirty write-backs",
               hits, misses, writebacks);
      if (mismatches == 0 && reads_pending == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

/* set_assoc_writeback_cache.f */
rtl/sac_pkg.sv
rtl/sac_cdiv.sv
rtl/sac_ctrl.sv
rtl/sac_datapath.sv
rtl/set_assoc_writeback_cache.sv
rtl/sac_checker.sv
tb/sv/set_assoc_writeback_cache_checker.sv
tb/sv/set_assoc_writeback_cache_tb.sv
